// ===== rtl/skvlt_pkg.sv =====
package skvlt_pkg;

	localparam int KeyW   = 32;
	localparam int ValW   = 32;
	localparam int CountW = 7;
	localparam int MaxW   = 7;

	localparam logic [MaxW-1:0] MaxEntriesReset = 7'd64;

	typedef enum logic [1:0] {
		OP_LOOKUP = 2'd0,
		OP_INSERT = 2'd1,
		OP_REMOVE = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_DUPLICATE = 2'd2,
		ST_FULL      = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		FSM_IDLE,
		FSM_SEARCH,
		FSM_APPLY
	} fsm_t;

	typedef struct packed {
		op_t             op;
		logic [KeyW-1:0] key;
		logic [ValW-1:0] value;
	} req_t;

	typedef struct packed {
		status_t           status;
		logic [ValW-1:0]   value_out;
		logic [CountW-1:0] count;
	} rsp_t;

	// Broadcast from the controller to every cell of the row.
	typedef struct packed {
		logic            capture;
		logic            ins;
		logic            rem;
		logic [KeyW-1:0] key;
		logic [ValW-1:0] value;
	} cell_cmd_t;

endpackage

// ===== rtl/skvlt_cell.sv =====
module skvlt_cell import skvlt_pkg::*; #(
	parameter int INDEX = 0,
	parameter int CW    = 7
) (
	input  logic            clk,
	input  logic            arst_n,
	input  cell_cmd_t       cmd,
	input  logic [CW-1:0]   count,
	input  logic            left_lt,
	input  logic [KeyW-1:0] left_key,
	input  logic [ValW-1:0] left_val,
	input  logic [KeyW-1:0] right_key,
	input  logic [ValW-1:0] right_val,
	output logic            lt,
	output logic            eq,
	output logic [KeyW-1:0] key,
	output logic [ValW-1:0] val,
	output logic [ValW-1:0] hit_val
);

	localparam logic [CW-1:0] Idx = CW'(INDEX);

	logic            occ;
	logic            lt_s1;
	logic            eq_s1;
	logic [KeyW-1:0] key_q;
	logic [ValW-1:0] val_q;

	// Only cells below the entry count take part in the search.
	assign occ = Idx < count;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lt_s1 <= 1'b0;
			eq_s1 <= 1'b0;
		end else if (cmd.capture) begin
			lt_s1 <= occ && (key_q < cmd.key);
			eq_s1 <= occ && (key_q == cmd.key);
		end
	end

	// Cells below the insertion point keep their entry; the rest move.
	always_ff @(posedge clk) begin
		if (cmd.ins && !lt_s1) begin
			if (left_lt) begin
				key_q <= cmd.key;
				val_q <= cmd.value;
			end else begin
				key_q <= left_key;
				val_q <= left_val;
			end
		end else if (cmd.rem && !lt_s1) begin
			key_q <= right_key;
			val_q <= right_val;
		end
	end

	assign lt      = lt_s1;
	assign eq      = eq_s1;
	assign key     = key_q;
	assign val     = val_q;
	assign hit_val = eq_s1 ? val_q : '0;

endmodule

// ===== rtl/skvlt_ctrl.sv =====
module skvlt_ctrl import skvlt_pkg::*; #(
	parameter int DEPTH = 64,
	parameter int CW    = 7
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  req_t            in_data,
	output logic            out_valid,
	input  logic            out_stall,
	output rsp_t            out_data,
	input  logic            cfg_we,
	input  logic [MaxW-1:0] cfg_data,
	input  logic            hit,
	input  logic [ValW-1:0] found_val,
	output cell_cmd_t       cmd,
	output logic [CW-1:0]   count
);

	localparam int LW = (CW > MaxW) ? CW : MaxW;
	localparam logic [LW-1:0] DepthL = LW'(DEPTH);

	fsm_t            state_q;
	fsm_t            state_d;
	req_t            req_q;
	logic [CW-1:0]   count_q;
	logic [MaxW-1:0] max_q;
	logic            out_valid_q;
	rsp_t            out_q;
	logic            advance;
	logic            accept;
	logic [LW-1:0]   max_l;
	logic [LW-1:0]   limit;
	logic [LW-1:0]   count_l;
	logic            full;
	logic [CW-1:0]   count_next;
	rsp_t            rsp;

	assign advance = !out_valid_q || !out_stall;
	assign accept  = in_valid && !in_stall;

	assign max_l   = LW'(max_q);
	assign limit   = (max_l > DepthL) ? DepthL : max_l;
	assign count_l = LW'(count_q);
	assign full    = count_l >= limit;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			FSM_IDLE:   if (accept) state_d = FSM_SEARCH;
			FSM_SEARCH: state_d = FSM_APPLY;
			FSM_APPLY: begin
				if (advance) state_d = accept ? FSM_SEARCH : FSM_IDLE;
			end
			default:    state_d = FSM_IDLE;
		endcase
	end

	always_comb begin
		in_stall    = 1'b1;
		cmd.capture = 1'b0;
		cmd.ins     = 1'b0;
		cmd.rem     = 1'b0;
		cmd.key     = req_q.key;
		cmd.value   = req_q.value;
		unique case (state_q)
			FSM_IDLE:   in_stall = 1'b0;
			FSM_SEARCH: cmd.capture = 1'b1;
			FSM_APPLY: begin
				in_stall = !advance;
				cmd.ins  = advance && (req_q.op == OP_INSERT) && !hit && !full;
				cmd.rem  = advance && (req_q.op == OP_REMOVE) && hit;
			end
			default:    in_stall = 1'b1;
		endcase
	end

	always_comb begin
		count_next = count_q;
		if (cmd.ins) count_next = count_q + CW'(1);
		else if (cmd.rem) count_next = count_q - CW'(1);
	end

	always_comb begin
		rsp.status    = ST_OK;
		rsp.value_out = '0;
		rsp.count     = CountW'(LW'(count_next));
		unique case (req_q.op)
			OP_LOOKUP: begin
				if (hit) rsp.value_out = found_val;
				else rsp.status = ST_NOT_FOUND;
			end
			OP_INSERT: begin
				if (hit) rsp.status = ST_DUPLICATE;
				else if (full) rsp.status = ST_FULL;
			end
			OP_REMOVE: begin
				if (!hit) rsp.status = ST_NOT_FOUND;
			end
			default: rsp.status = ST_OK;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= FSM_IDLE;
			count_q     <= '0;
			max_q       <= MaxEntriesReset;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_next;
			if (cfg_we) max_q <= cfg_data;
			if (state_q == FSM_APPLY && advance) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) req_q <= in_data;
		if (state_q == FSM_APPLY && advance) out_q <= rsp;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign count     = count_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		LW'(count_q) <= DepthL)
		else $error("entry count above table depth");

	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ins |=> count_q == $past(count_q) + CW'(1))
		else $error("accepted insert did not grow the count");

	a_remove_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rem |-> count_q != '0)
		else $error("remove on an empty table");

	a_result_after_apply: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == FSM_APPLY)
		else $error("result issued outside the update cycle");

endmodule

// ===== rtl/sorted_key_value_leaf_table.sv =====
// Sorted key/value leaf table. The table is a row of DEPTH cells, each
// holding one key/value pair; the pairs stay in ascending unsigned key
// order. Every request passes a search state and then an apply state: in
// the first, all cells compare their stored key against the request key at
// once and register the result; in the second, each cell decides from its
// own flags and its left neighbor's flag whether it keeps its pair, takes
// the new pair, or takes the pair of a neighbor, so an insert or remove
// shifts the whole row in one step. The result is then held in an output
// register, and a new request can be accepted in that same update cycle,
// but none is accepted while a search is under way. A waiting result that
// is stalled holds the update back. Cell contents need no clearing after
// reset: only cells below the entry count take part in a search.
module sorted_key_value_leaf_table import skvlt_pkg::*; #(
	parameter int DEPTH = 64
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  req_t            in_data,
	output logic            out_valid,
	input  logic            out_stall,
	output rsp_t            out_data,
	input  logic            cfg_we,
	input  logic [MaxW-1:0] cfg_data
);

	// The count must be able to hold DEPTH itself.
	localparam int CW = $clog2(DEPTH + 1);

	cell_cmd_t       cmd;
	logic [CW-1:0]   count;
	logic            hit;
	logic [ValW-1:0] found_val;

	logic [DEPTH-1:0] lt_vec;
	logic [DEPTH-1:0] eq_vec;
	logic [KeyW-1:0]  key_arr [DEPTH];
	logic [ValW-1:0]  val_arr [DEPTH];
	logic [ValW-1:0]  hit_arr [DEPTH];

	skvlt_ctrl #(
		.DEPTH(DEPTH),
		.CW   (CW)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.hit      (hit),
		.found_val(found_val),
		.cmd      (cmd),
		.count    (count)
	);

	// The row of cells. The first cell sees a "less than" on its left, so
	// it is the insertion point whenever its own key is not below the
	// request key. The last cell's right neighbor is itself; its contents
	// beyond the count are never read.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic            left_lt;
		logic [KeyW-1:0] left_key;
		logic [ValW-1:0] left_val;
		logic [KeyW-1:0] right_key;
		logic [ValW-1:0] right_val;

		if (i == 0) begin : g_first
			assign left_lt  = 1'b1;
			assign left_key = key_arr[i];
			assign left_val = val_arr[i];
		end else begin : g_mid
			assign left_lt  = lt_vec[i-1];
			assign left_key = key_arr[i-1];
			assign left_val = val_arr[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign right_key = key_arr[i];
			assign right_val = val_arr[i];
		end else begin : g_inner
			assign right_key = key_arr[i+1];
			assign right_val = val_arr[i+1];
		end

		skvlt_cell #(
			.INDEX(i),
			.CW   (CW)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cmd      (cmd),
			.count    (count),
			.left_lt  (left_lt),
			.left_key (left_key),
			.left_val (left_val),
			.right_key(right_key),
			.right_val(right_val),
			.lt       (lt_vec[i]),
			.eq       (eq_vec[i]),
			.key      (key_arr[i]),
			.val      (val_arr[i]),
			.hit_val  (hit_arr[i])
		);
	end

	// Keys are distinct, so at most one cell matches. Each cell presents
	// its value only on a match, and the found value is the OR of the row,
	// taken one bit column at a time.
	assign hit = |eq_vec;

	for (genvar b = 0; b < ValW; b++) begin : g_col
		logic [DEPTH-1:0] column;
		for (genvar i = 0; i < DEPTH; i++) begin : g_bit
			assign column[i] = hit_arr[i][b];
		end
		assign found_val[b] = |column;
	end

endmodule

// ===== test/tb.sv =====
// Testbench for the sorted key/value leaf table.
//
// A driver process offers requests from a queue that the stimulus process
// fills. At each accepted request, a behavioral copy of the table inside the
// testbench computes the response. The copy is a sorted array with an entry
// count and a capacity limit. The response goes into a queue, and a monitor
// process checks every delivered response, field by field, against the
// oldest entry in that queue. The capacity register is written only while
// nothing is in flight. The run goes through zero, small, default, lowered
// and oversized limits.
module tb import skvlt_pkg::*;;

	localparam int TABLE_DEPTH = 64;
	localparam int RX_HOLD_CYCLES = 200;
	localparam int KEY_POOL_SIZE = 128;
	localparam int MAX_REPORTS = 10;
	localparam int DRAIN_CYCLES = 10;

	// The block treats the fourth operation code as a no-op. The package enum
	// does not name it, so it is built here by a cast.
	localparam op_t OP_UNUSED = op_t'(2'd3);

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	req_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	rsp_t out_data;
	logic cfg_we = 1'b0;
	logic [MaxW-1:0] cfg_data = MaxEntriesReset;

	sorted_key_value_leaf_table #(
		.DEPTH(TABLE_DEPTH)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// The testbench's own copy of the table. Only entries below held_entries
	// are meaningful, which mirrors the block: cells above the count are
	// never searched.
	logic [KeyW-1:0] shadow_keys [TABLE_DEPTH];
	logic [ValW-1:0] shadow_vals [TABLE_DEPTH];
	int held_entries = 0;
	int limit_setting = int'(MaxEntriesReset);

	// Requests waiting to be offered, and responses waiting to be delivered.
	req_t pending_requests [$];
	rsp_t expected_responses [$];

	// Idle and stall rates, in percent, that the stimulus process changes
	// between phases.
	int send_idle_pct = 0;
	int recv_stall_pct = 0;

	// The long receiver hold-off has its own countdown. The stimulus process
	// raises hold_go for one clock to start it.
	logic hold_go = 1'b0;
	int hold_left = 0;

	int mismatches = 0;
	int responses_seen = 0;
	logic [KeyW-1:0] key_pool [KEY_POOL_SIZE];

	// Applies one request to the shadow table and returns the response that
	// the block must give for it. The search finds the first entry whose key
	// is not below the request key. That position is a hit when it holds the
	// key itself, and it is the insertion point otherwise.
	function automatic rsp_t leaf_apply(req_t rq);
		rsp_t rsp;
		int pos;
		int cap;
		bit hit;
		rsp.status = ST_OK;
		rsp.value_out = '0;
		pos = 0;
		while (pos < held_entries && shadow_keys[pos] < rq.key)
			pos++;
		hit = (pos < held_entries) && (shadow_keys[pos] == rq.key);
		// A limit above the physical depth acts as the depth.
		cap = (limit_setting > TABLE_DEPTH) ? TABLE_DEPTH : limit_setting;
		case (rq.op)
			OP_LOOKUP: begin
				if (hit)
					rsp.value_out = shadow_vals[pos];
				else
					rsp.status = ST_NOT_FOUND;
			end
			OP_INSERT: begin
				// The duplicate check comes before the capacity check.
				if (hit) begin
					rsp.status = ST_DUPLICATE;
				end else if (held_entries >= cap) begin
					rsp.status = ST_FULL;
				end else begin
					for (int i = held_entries; i > pos; i--) begin
						shadow_keys[i] = shadow_keys[i-1];
						shadow_vals[i] = shadow_vals[i-1];
					end
					shadow_keys[pos] = rq.key;
					shadow_vals[pos] = rq.value;
					held_entries++;
				end
			end
			OP_REMOVE: begin
				if (!hit) begin
					rsp.status = ST_NOT_FOUND;
				end else begin
					for (int i = pos; i + 1 < held_entries; i++) begin
						shadow_keys[i] = shadow_keys[i+1];
						shadow_vals[i] = shadow_vals[i+1];
					end
					held_entries--;
				end
			end
			default: ;
		endcase
		rsp.count = CountW'(held_entries);
		return rsp;
	endfunction

	// Driver. A request that is offered stays on the bus, unchanged, until it
	// is accepted. Only then may the next request be offered, or an idle cycle
	// be inserted. The response is predicted at the edge that accepts the
	// request, so the shadow table follows the block's own order.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				expected_responses.push_back(leaf_apply(in_data));
			if (!in_valid || !in_stall) begin
				if (pending_requests.size() > 0 &&
				    $urandom_range(99) >= send_idle_pct) begin
					in_data <= pending_requests.pop_front();
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Countdown for the long hold-off. While it runs, the monitor keeps
	// out_stall high and the driver keeps offering requests. The block must
	// fill up and push back on its input.
	always @(posedge clk) begin
		if (hold_left > 0)
			hold_left <= hold_left - 1;
		else if (hold_go)
			hold_left <= RX_HOLD_CYCLES;
	end

	// Monitor. A response counts as delivered at an edge where out_valid is
	// high and out_stall is low. It must match the oldest expected response.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				responses_seen++;
				if (expected_responses.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display({"response %0d arrived with nothing expected: ",
						          "status %0d value %h count %0d"},
						         responses_seen, out_data.status,
						         out_data.value_out, out_data.count);
				end else begin
					rsp_t exp_rsp;
					exp_rsp = expected_responses.pop_front();
					if (out_data.status !== exp_rsp.status ||
					    out_data.value_out !== exp_rsp.value_out ||
					    out_data.count !== exp_rsp.count) begin
						mismatches++;
						if (mismatches <= MAX_REPORTS)
							$display({"response %0d: expected status %0d ",
							          "value %h count %0d, got status %0d ",
							          "value %h count %0d"},
							         responses_seen, exp_rsp.status,
							         exp_rsp.value_out, exp_rsp.count,
							         out_data.status, out_data.value_out,
							         out_data.count);
					end
				end
			end
			out_stall <= (hold_left > 0) || ($urandom_range(99) < recv_stall_pct);
		end
	end

	task automatic push_req(op_t op, logic [KeyW-1:0] key, logic [ValW-1:0] value);
		req_t rq;
		rq.op = op;
		rq.key = key;
		rq.value = value;
		pending_requests.push_back(rq);
	endtask

	// Queues n random requests. Most keys come from the first pool_len entries
	// of the key pool, so lookups, removes and duplicate inserts hit often. A
	// few keys are fully random. The insert and remove shares steer the entry
	// count up or down. Lookups take most of the remainder, and a small share
	// uses the unused operation code.
	task automatic queue_burst(int n, int pool_len, int ins_pct, int rem_pct);
		int pick;
		op_t op;
		logic [KeyW-1:0] key;
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(99);
			if (pick < ins_pct)
				op = OP_INSERT;
			else if (pick < ins_pct + rem_pct)
				op = OP_REMOVE;
			else if (pick < 98)
				op = OP_LOOKUP;
			else
				op = OP_UNUSED;
			if ($urandom_range(99) < 90)
				key = key_pool[$urandom_range(pool_len - 1)];
			else
				key = $urandom;
			push_req(op, key, $urandom);
		end
	endtask

	// Lets every queued request be accepted and every response be delivered.
	// It then keeps waiting, with nothing sent, so that the block is certainly idle.
	task automatic wait_drained();
		while (pending_requests.size() != 0 || in_valid || expected_responses.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// Writes the capacity register while nothing is in flight. The shadow
	// limit changes at the same edge as the block's register.
	task automatic write_limit(int limit);
		wait_drained();
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_data <= MaxW'(limit);
		@(posedge clk);
		cfg_we <= 1'b0;
		limit_setting = limit;
	endtask

	task automatic long_hold(int n_requests, int pool_len);
		@(negedge clk);
		hold_go = 1'b1;
		@(negedge clk);
		hold_go = 1'b0;
		queue_burst(n_requests, pool_len, 50, 20);
	endtask

	initial begin
		key_pool[0] = '0;
		key_pool[1] = '1;
		key_pool[2] = 32'h8000_0000;
		for (int i = 3; i < KEY_POOL_SIZE; i++)
			key_pool[i] = $urandom;

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// First phase: a slow receiver and a mostly busy sender.
		send_idle_pct = 23;
		recv_stall_pct = 85;

		// Directed requests at the reset limit of 64. The table starts empty,
		// so the first lookup and remove must miss with a count of zero. The
		// inserts that follow use the extreme keys and values, and a repeated
		// key checks the duplicate case.
		push_req(OP_LOOKUP, 32'h0000_0000, 32'h0000_0000);
		push_req(OP_REMOVE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		push_req(OP_UNUSED, 32'h1234_5678, 32'hFFFF_FFFF);
		push_req(OP_INSERT, 32'h0000_0000, 32'hFFFF_FFFF);
		push_req(OP_INSERT, 32'hFFFF_FFFF, 32'h0000_0000);
		push_req(OP_INSERT, 32'h8000_0000, 32'h5A5A_A5A5);
		push_req(OP_INSERT, 32'h0000_0000, 32'h1111_1111);
		push_req(OP_INSERT, 32'h0000_0001, 32'hA5A5_5A5A);
		push_req(OP_INSERT, 32'h7FFF_FFFF, 32'h8000_0001);
		push_req(OP_LOOKUP, 32'h0000_0000, 32'h0000_0000);
		push_req(OP_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		push_req(OP_LOOKUP, 32'h8000_0000, 32'h0000_0000);
		push_req(OP_LOOKUP, 32'h0000_0001, 32'h0000_0000);
		push_req(OP_LOOKUP, 32'h0000_0002, 32'h0000_0000);
		push_req(OP_REMOVE, 32'h8000_0000, 32'h0000_0000);
		push_req(OP_LOOKUP, 32'h8000_0000, 32'h0000_0000);
		push_req(OP_REMOVE, 32'h0000_0000, 32'h0000_0000);
		push_req(OP_REMOVE, 32'h0000_0000, 32'h0000_0000);
		push_req(OP_UNUSED, 32'hFFFF_FFFF, 32'h0000_0000);
		push_req(OP_LOOKUP, 32'h7FFF_FFFF, 32'h0000_0000);

		// Zero capacity refuses every insert. The entries already held stay
		// visible to lookups and removes.
		write_limit(0);
		queue_burst(30, 8, 60, 10);

		// The largest register value acts as the full depth. An insert-heavy
		// run fills the table and then hits the full case.
		write_limit(127);
		queue_burst(150, 100, 70, 10);

		// The receiver holds off for a long stretch while requests keep
		// coming. The sender then pauses until every response is back.
		long_hold(60, 100);
		wait_drained();
		queue_burst(100, 100, 40, 35);

		// Second phase: the roles of the two sides are swapped.
		write_limit(10);
		send_idle_pct = 85;
		recv_stall_pct = 23;
		// The limit now sits below the count. Inserts stay refused until
		// removes bring the count under the limit.
		queue_burst(100, 100, 45, 30);
		write_limit(1);
		queue_burst(80, 8, 40, 40);
		write_limit(64);
		queue_burst(150, 24, 40, 35);

		// Third phase: neither side idles, so requests go back to back.
		write_limit(100);
		send_idle_pct = 0;
		recv_stall_pct = 0;
		queue_burst(200, 128, 70, 10);
		queue_burst(200, 128, 20, 60);
		write_limit(64);
		queue_burst(200, 48, 40, 35);
		long_hold(40, 48);

		wait_drained();
		if (mismatches == 0 && expected_responses.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	// Safety net: a correct run ends far sooner than this.
	initial begin
		#4_000_000;
		$display("Verification failed");
		$finish;
	end

endmodule
